>>> src/number_literal_checker_core_assert.svh
// Assertion macros for the checker file of the literal checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef NUMBER_LITERAL_CHECKER_CORE_ASSERT_SVH
`define NUMBER_LITERAL_CHECKER_CORE_ASSERT_SVH

// Clocked property, off while reset is low, generic message.
`define NLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nlc assertion failed");

// Same, with a caller-supplied message.
`define NLC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

>>> src/nlc_pkg.sv
// Package for the numeric literal checker: scanner state codes,
// character constants and the transition result type. No dependencies.
package nlc_pkg;

  typedef enum logic [3:0] {
    SCAN_START   = 4'd0,
    SCAN_SIGN    = 4'd1,
    SCAN_INT     = 4'd2,
    SCAN_DOT     = 4'd3,
    SCAN_FSIGN   = 4'd4,
    SCAN_FRAC    = 4'd5,
    SCAN_EXPMARK = 4'd6,
    SCAN_ESIGN   = 4'd7,
    SCAN_EXP     = 4'd8,
    SCAN_ERR     = 4'd15
  } scan_e;

  localparam logic [7:0] CHAR_E     = 8'h65;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;

  typedef struct packed {
    scan_e next_state;
    logic  accept;
  } step_t;

endpackage

>>> src/nlc_step.sv
// Scanner transition: next state and accept flag for one character.
// Depends on nlc_pkg.
module nlc_step (
  input  nlc_pkg::scan_e scan_state_i,
  input  logic [7:0]     char_code_i,
  output nlc_pkg::step_t step_o
);
  import nlc_pkg::*;

  logic  is_digit;
  logic  is_sign;
  scan_e next_state;

  assign is_digit = char_code_i inside {[CHAR_0:CHAR_9]};
  assign is_sign  = (char_code_i == CHAR_PLUS) || (char_code_i == CHAR_MINUS);

  always_comb begin
    next_state = SCAN_ERR;
    case (scan_state_i)
      SCAN_START: begin
        if (is_sign) next_state = SCAN_SIGN;
        else if (is_digit) next_state = SCAN_INT;
      end
      SCAN_SIGN: begin
        if (is_digit) next_state = SCAN_INT;
      end
      SCAN_INT: begin
        if (is_digit) next_state = SCAN_INT;
        else if (char_code_i == CHAR_DOT) next_state = SCAN_DOT;
        else if (char_code_i == CHAR_E) next_state = SCAN_EXPMARK;
      end
      SCAN_DOT: begin
        if (char_code_i == CHAR_PLUS) next_state = SCAN_FSIGN;
        else if (is_digit) next_state = SCAN_FRAC;
      end
      SCAN_FSIGN: begin
        if (is_digit) next_state = SCAN_FRAC;
      end
      SCAN_FRAC: begin
        if (is_digit) next_state = SCAN_FRAC;
        else if (char_code_i == CHAR_E) next_state = SCAN_EXPMARK;
      end
      SCAN_EXPMARK: begin
        if (is_sign) next_state = SCAN_ESIGN;
        else if (is_digit) next_state = SCAN_EXP;
      end
      SCAN_ESIGN: begin
        if (is_digit) next_state = SCAN_EXP;
      end
      SCAN_EXP: begin
        if (is_digit) next_state = SCAN_EXP;
      end
      default: begin
        next_state = SCAN_ERR;
      end
    endcase
  end

  assign step_o.next_state = next_state;
  assign step_o.accept     = (next_state == SCAN_INT) || (next_state == SCAN_FRAC) ||
                             (next_state == SCAN_EXP);

endmodule

>>> src/number_literal_checker_core.sv
// Numeric literal checker top level: input register, scanner state, result register.
// One character per cycle unless a final one waits for result room; the scan state
// loop is one nlc_step pass. A final verdict passes input, then result register.
// Reset empties both registers and returns the scanner to the start state.
// Depends on nlc_pkg and nlc_step.
module number_literal_checker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);
  import nlc_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_final_q;
  scan_e      scan_q;
  logic       out_valid_q;
  logic       out_res_q;

  logic       out_room;
  logic       s1_move;
  logic       in_fire;
  step_t      step;

  nlc_step u_step (
    .scan_state_i (scan_q),
    .char_code_i  (s1_char_q),
    .step_o       (step)
  );

  assign out_room   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && (!s1_final_q || out_room);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      scan_q      <= SCAN_START;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_move) begin
        scan_q <= s1_final_q ? SCAN_START : step.next_state;
      end
      if (s1_move && s1_final_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q  <= char_code_i;
      s1_final_q <= is_final_i;
    end
    if (s1_move && s1_final_q) out_res_q <= step.accept;
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = out_res_q;

endmodule

>>> src/nlc_checker.sv
// Port-level checks for number_literal_checker_core, with its bind.
// Depends on nlc_pkg and number_literal_checker_core_assert.svh.
`include "number_literal_checker_core_assert.svh"

module nlc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] char_code_i,
  input logic       is_final_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       valid_res_o
);
  import nlc_pkg::*;

  `NLC_ASSERT(out_hold_a, out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_res_o))
  `NLC_ASSERT_MSG(ready_when_empty_a, !out_valid_o |-> in_ready_o, "input stalled while output empty")
  `NLC_ASSERT_MSG(result_from_final_a, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && is_final_i, 2), "result without final transaction")
  `NLC_ASSERT_MSG(nondigit_end_rejects_a, $rose(out_valid_o) && $past(char_code_i < CHAR_0 || char_code_i > CHAR_9, 2) |-> !valid_res_o, "literal ending in non-digit accepted")

endmodule

bind number_literal_checker_core nlc_checker u_nlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .char_code_i (char_code_i),
  .is_final_i  (is_final_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .valid_res_o (valid_res_o)
);

>>> verif/testbench.sv
// Self-checking testbench for number_literal_checker_core: streams numeric literals one
// character per transaction and predicts each final-character verdict with its own scanner.
// Depends on nlc_pkg and the core RTL.
module testbench;
  import nlc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 5;
  localparam int CHAR_TARGET   = 800;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int LONG_HOLD     = 250;
  localparam int HOLD_AFTER    = 150;

  class verdict_scoreboard;
    scan_e scan_st;
    bit    expected_verdicts[$];
    int    errors;

    function new();
      scan_st = SCAN_START;
      errors  = 0;
    endfunction

    function scan_e scan_next(scan_e s, logic [7:0] c);
      logic digit;
      logic pm;
      digit = (c >= CHAR_0) && (c <= CHAR_9);
      pm    = (c == CHAR_PLUS) || (c == CHAR_MINUS);
      case (s)
        SCAN_START:   return pm ? SCAN_SIGN : (digit ? SCAN_INT : SCAN_ERR);
        SCAN_SIGN:    return digit ? SCAN_INT : SCAN_ERR;
        SCAN_INT: begin
          if (digit) return SCAN_INT;
          if (c == CHAR_DOT) return SCAN_DOT;
          if (c == CHAR_E) return SCAN_EXPMARK;
          return SCAN_ERR;
        end
        SCAN_DOT: begin
          if (c == CHAR_PLUS) return SCAN_FSIGN;
          return digit ? SCAN_FRAC : SCAN_ERR;
        end
        SCAN_FSIGN:   return digit ? SCAN_FRAC : SCAN_ERR;
        SCAN_FRAC: begin
          if (digit) return SCAN_FRAC;
          if (c == CHAR_E) return SCAN_EXPMARK;
          return SCAN_ERR;
        end
        SCAN_EXPMARK: return pm ? SCAN_ESIGN : (digit ? SCAN_EXP : SCAN_ERR);
        SCAN_ESIGN:   return digit ? SCAN_EXP : SCAN_ERR;
        SCAN_EXP:     return digit ? SCAN_EXP : SCAN_ERR;
        default:      return SCAN_ERR;
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      scan_e nxt;
      nxt = scan_next(scan_st, c);
      if (fin) begin
        expected_verdicts.push_back(nxt == SCAN_INT || nxt == SCAN_FRAC || nxt == SCAN_EXP);
        scan_st = SCAN_START;
      end else begin
        scan_st = nxt;
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_verdict(logic got);
      bit want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result transaction, valid_res=%b", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want)
          report($sformatf("valid_res got %b want %b", got, want));
      end
    endtask

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] char_code_i = 8'h00;
  logic       is_final_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       valid_res_o;

  verdict_scoreboard sb = new();

  int         char_count;
  int         burst_left;
  int         idle_cycles;
  int         mode_left;
  int         stall_mode;
  int         hold_left;
  bit         hold_done;
  bit         toggle_bit;
  logic [7:0] lit_q[$];

  number_literal_checker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_code_i(char_code_i),
    .is_final_i (is_final_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .valid_res_o(valid_res_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    is_final_i  <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_char(c, fin);
    char_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_literal();
    for (int i = 0; i < lit_q.size(); i++)
      send_char(lit_q[i], i == lit_q.size() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return CHAR_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_special();
    case ($urandom_range(0, 7))
      0: return CHAR_DOT;
      1: return CHAR_E;
      2: return 8'h45;
      3: return CHAR_MINUS;
      4: return CHAR_PLUS;
      5: return rand_digit();
      6: return CHAR_0 - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_number();
    lit_q.delete();
    if ($urandom_range(0, 1)) lit_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
    repeat ($urandom_range(1, 4)) lit_q.push_back(rand_digit());
    if ($urandom_range(0, 1)) begin
      lit_q.push_back(CHAR_DOT);
      if ($urandom_range(0, 2) == 0) lit_q.push_back(CHAR_PLUS);
      repeat ($urandom_range(1, 3)) lit_q.push_back(rand_digit());
    end
    if ($urandom_range(0, 4) < 2) begin
      lit_q.push_back(CHAR_E);
      if ($urandom_range(0, 1)) lit_q.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
      repeat ($urandom_range(1, 3)) lit_q.push_back(rand_digit());
    end
  endfunction

  function automatic void break_number();
    int idx;
    idx = $urandom_range(0, lit_q.size() - 1);
    case ($urandom_range(0, 2))
      0: lit_q[idx] = rand_special();
      1: lit_q.insert(idx, rand_special());
      default: while (lit_q.size() > idx + 1) void'(lit_q.pop_back());
    endcase
  endfunction

  function automatic void build_noise();
    lit_q.delete();
    repeat ($urandom_range(1, 6))
      lit_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : rand_special());
  endfunction

  // receiver: changing stall modes plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_verdict(valid_res_o);
      if (!hold_done && char_count >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      toggle_bit = ~toggle_bit;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= toggle_bit;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    char_count  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    mode_left   = 0;
    stall_mode  = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    toggle_bit  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, every scanner state and the error cases
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    send_text("7");
    send_text("-1.+0e+9");
    send_text("1.-2");
    send_text("1.e5");
    send_text("2E3");
    send_text("1.2.");
    send_text("3e1e");

    while (char_count < CHAR_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1: build_noise();
        2, 3, 4: begin
          build_number();
          break_number();
        end
        default: build_number();
      endcase
      send_literal();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/nlc_pkg.sv
src/nlc_step.sv
src/number_literal_checker_core.sv
src/nlc_checker.sv
verif/testbench.sv
